// ----- src/antialiased_line_stepper_assert.svh -----
// assertion macros for the checker of the line stepper
`ifndef ANTIALIASED_LINE_STEPPER_ASSERT_SVH
`define ANTIALIASED_LINE_STEPPER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define ALS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("als check failed: label");

// next-cycle implication
`define ALS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("als check failed: label");

`endif

// ----- src/als_pkg.sv -----
package als_pkg;

  localparam int unsigned COORD_W      = 6;
  localparam int unsigned COLOR_W      = 24;
  localparam int unsigned WEIGHT_W     = 9;
  localparam int unsigned FRAC_W       = 8;
  localparam int unsigned ERR_W        = 7;
  localparam int unsigned SIDE_DEFAULT = 56;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(1 << FRAC_W);

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] color;
  } line_t;

  typedef struct packed {
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic                x_major;
    logic [WEIGHT_W-1:0] weight_minus;
    logic [WEIGHT_W-1:0] weight_plus;
    logic [COLOR_W-1:0]  pixel_color;
    logic                last;
  } result_t;

  // classified line, ordered so the walk goes upward along the major axis
  typedef struct packed {
    logic [COORD_W-1:0] major_start;
    logic [COORD_W-1:0] minor_start;
    logic [COORD_W-1:0] major_stop;
    logic [COORD_W-1:0] minor_stop;
    logic [COORD_W-1:0] delta_minor;
    logic               minor_positive;
    logic               major_is_x;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- src/als_front.sv -----
module als_front #(
  parameter int unsigned SIDE = als_pkg::SIDE_DEFAULT
) (
  input  als_pkg::line_t line_i,
  output als_pkg::cmd_t  cmd_o
);
  import als_pkg::*;

  localparam logic [COORD_W-1:0] MaxCoord = COORD_W'(SIDE - 1);

  logic [COORD_W-1:0] xa, ya, xb, yb;
  logic [COORD_W-1:0] dx, dy;
  logic [COORD_W-1:0] ma, na, mb, nb;
  logic               x_is_major;

  always_comb begin
    xa = (line_i.x_start > MaxCoord) ? MaxCoord : line_i.x_start;
    ya = (line_i.y_start > MaxCoord) ? MaxCoord : line_i.y_start;
    xb = (line_i.x_end   > MaxCoord) ? MaxCoord : line_i.x_end;
    yb = (line_i.y_end   > MaxCoord) ? MaxCoord : line_i.y_end;
    dx = (xa >= xb) ? xa - xb : xb - xa;
    dy = (ya >= yb) ? ya - yb : yb - ya;
    x_is_major = (dx >= dy);
    // swap endpoints so the major coordinate rises
    if (x_is_major) begin
      if (xa > xb) begin
        ma = xb; na = yb; mb = xa; nb = ya;
      end else begin
        ma = xa; na = ya; mb = xb; nb = yb;
      end
    end else begin
      if (ya > yb) begin
        ma = yb; na = xb; mb = ya; nb = xa;
      end else begin
        ma = ya; na = xa; mb = yb; nb = xb;
      end
    end
    cmd_o.major_start    = ma;
    cmd_o.minor_start    = na;
    cmd_o.major_stop     = mb;
    cmd_o.minor_stop     = nb;
    cmd_o.delta_minor    = (na >= nb) ? na - nb : nb - na;
    cmd_o.minor_positive = (nb > na);
    cmd_o.major_is_x     = x_is_major;
    cmd_o.color          = line_i.color;
  end

endmodule

// ----- src/als_queue.sv -----
module als_queue #(
  parameter int unsigned DEPTH = als_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  als_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output als_pkg::cmd_t    cmd_o,
  output als_pkg::q_stat_t stat_o
);
  import als_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- src/als_back.sv -----
module als_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  als_pkg::q_stat_t stat_i,
  input  als_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  output logic             strobe_o,
  output als_pkg::result_t result_o
);
  import als_pkg::*;

  localparam int unsigned CntW = $clog2(FRAC_W);
  localparam logic [CntW-1:0] LastIter = CntW'(FRAC_W - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StStep = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StEnd  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [COORD_W-1:0] cur_major_q, cur_major_d;
  logic [COORD_W-1:0] cur_minor_q, cur_minor_d;
  logic [COORD_W-1:0] stop_major_q, stop_major_d;
  logic [COORD_W-1:0] stop_minor_q, stop_minor_d;
  logic [COORD_W-1:0] delta_major_q, delta_major_d;
  logic [COORD_W-1:0] delta_minor_q, delta_minor_d;
  logic [ERR_W-1:0]   err_q, err_d;
  logic               pos_q, pos_d;
  logic               mx_q, mx_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic [ERR_W-1:0]   rem_q, rem_d;
  logic [FRAC_W-1:0]  quot_q, quot_d;
  logic [CntW-1:0]    iter_q, iter_d;
  logic               strobe_q, strobe_d;
  result_t            result_q, result_d;

  logic [ERR_W-1:0]  err_ext_dmaj, err_ext_dmin;
  logic [ERR_W-1:0]  rem_shift;
  logic              rem_ge;
  logic [FRAC_W-1:0] quot_next;
  logic [WEIGHT_W-1:0] q_wide;

  function automatic result_t pack_result(logic mx, logic [COORD_W-1:0] maj,
                                          logic [COORD_W-1:0] mnr,
                                          logic [WEIGHT_W-1:0] wm,
                                          logic [WEIGHT_W-1:0] wp,
                                          logic [COLOR_W-1:0] col, logic lst);
    result_t r;
    r.pixel_x      = mx ? maj : mnr;
    r.pixel_y      = mx ? mnr : maj;
    r.x_major      = mx;
    r.weight_minus = wm;
    r.weight_plus  = wp;
    r.pixel_color  = col;
    r.last         = lst;
    return r;
  endfunction

  assign err_ext_dmaj = ERR_W'(delta_major_q);
  assign err_ext_dmin = ERR_W'(delta_minor_q);
  // one restoring division step per cycle
  assign rem_shift = {rem_q[ERR_W-2:0], 1'b0};
  assign rem_ge    = (rem_shift >= err_ext_dmaj);
  assign quot_next = {quot_q[FRAC_W-2:0], rem_ge};
  assign q_wide    = WEIGHT_W'(quot_next);

  assign pop_o    = (state_q == StIdle) && !stat_i.empty;
  assign strobe_o = strobe_q;
  assign result_o = result_q;

  always_comb begin
    state_d       = state_q;
    cur_major_d   = cur_major_q;
    cur_minor_d   = cur_minor_q;
    stop_major_d  = stop_major_q;
    stop_minor_d  = stop_minor_q;
    delta_major_d = delta_major_q;
    delta_minor_d = delta_minor_q;
    err_d         = err_q;
    pos_d         = pos_q;
    mx_d          = mx_q;
    color_d       = color_q;
    rem_d         = rem_q;
    quot_d        = quot_q;
    iter_d        = iter_q;
    strobe_d      = 1'b0;
    result_d      = result_q;
    unique case (state_q)
      StIdle: begin
        if (!stat_i.empty) begin
          cur_major_d   = cmd_i.major_start;
          cur_minor_d   = cmd_i.minor_start;
          stop_major_d  = cmd_i.major_stop;
          stop_minor_d  = cmd_i.minor_stop;
          delta_major_d = cmd_i.major_stop - cmd_i.major_start;
          delta_minor_d = cmd_i.delta_minor;
          err_d         = ERR_W'(delta_major_d >> 1);
          pos_d         = cmd_i.minor_positive;
          mx_d          = cmd_i.major_is_x;
          color_d       = cmd_i.color;
          strobe_d      = 1'b1;
          result_d      = pack_result(cmd_i.major_is_x, cmd_i.major_start,
                                      cmd_i.minor_start, '0, '0, cmd_i.color, 1'b0);
          state_d       = (cmd_i.major_start < cmd_i.major_stop) ? StStep : StEnd;
        end
      end
      StStep: begin
        if (err_q < err_ext_dmin) begin
          err_d       = err_q + err_ext_dmaj - err_ext_dmin;
          cur_minor_d = pos_q ? cur_minor_q + 1'b1 : cur_minor_q - 1'b1;
        end else begin
          err_d = err_q - err_ext_dmin;
        end
        cur_major_d = cur_major_q + 1'b1;
        rem_d       = err_d;
        quot_d      = '0;
        iter_d      = '0;
        state_d     = StDiv;
      end
      StDiv: begin
        rem_d  = rem_ge ? rem_shift - err_ext_dmaj : rem_shift;
        quot_d = quot_next;
        iter_d = iter_q + 1'b1;
        if (iter_q == LastIter) begin
          strobe_d = 1'b1;
          // mirror the coverage when the minor coordinate rises
          if (pos_q) begin
            result_d = pack_result(mx_q, cur_major_q, cur_minor_q, q_wide,
                                   WEIGHT_FULL - q_wide, color_q, 1'b0);
          end else begin
            result_d = pack_result(mx_q, cur_major_q, cur_minor_q,
                                   WEIGHT_FULL - q_wide, q_wide, color_q, 1'b0);
          end
          state_d = (cur_major_q < stop_major_q) ? StStep : StEnd;
        end
      end
      StEnd: begin
        strobe_d = 1'b1;
        result_d = pack_result(mx_q, stop_major_q, stop_minor_q, '0, '0, color_q, 1'b1);
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_major_q   <= cur_major_d;
    cur_minor_q   <= cur_minor_d;
    stop_major_q  <= stop_major_d;
    stop_minor_q  <= stop_minor_d;
    delta_major_q <= delta_major_d;
    delta_minor_q <= delta_minor_d;
    err_q         <= err_d;
    pos_q         <= pos_d;
    mx_q          <= mx_d;
    color_q       <= color_d;
    rem_q         <= rem_d;
    quot_q        <= quot_d;
    iter_q        <= iter_d;
    result_q      <= result_d;
  end

endmodule

// ----- src/antialiased_line_stepper.sv -----
// start_i writes a queue entry; the idle walker pops it and registers the start word
// each step word then comes from one update state and the coverage divider state,
// so a line of major length d holds the walker for d step words plus start and end words
// a two-entry command queue takes new lines while the walker runs; busy_o means it is full
// results are never stalled; reset (rst_ni low) empties the queue and idles the walker
module antialiased_line_stepper #(
  parameter int unsigned SIDE  = als_pkg::SIDE_DEFAULT,
  parameter int unsigned QDEPTH = als_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  als_pkg::line_t   line_i,
  output logic             busy_o,
  output logic             result_strobe_o,
  output als_pkg::result_t result_o
);
  import als_pkg::*;

  cmd_t    front_cmd;
  cmd_t    queue_cmd;
  q_stat_t queue_stat;
  logic    back_pop;

  assign busy_o = queue_stat.full;

  als_front #(
    .SIDE (SIDE)
  ) u_front (
    .line_i (line_i),
    .cmd_o  (front_cmd)
  );

  als_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (start_i),
    .cmd_i  (front_cmd),
    .pop_i  (back_pop),
    .cmd_o  (queue_cmd),
    .stat_o (queue_stat)
  );

  als_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stat_i   (queue_stat),
    .cmd_i    (queue_cmd),
    .pop_o    (back_pop),
    .strobe_o (result_strobe_o),
    .result_o (result_o)
  );

endmodule

// ----- src/als_checker.sv -----
module als_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             result_strobe_o,
  input als_pkg::result_t result_o
);
  import als_pkg::*;

  `include "antialiased_line_stepper_assert.svh"

  logic no_weight;
  logic split_full;
  logic inner_word;

  assign no_weight  = (result_o.weight_minus == '0) && (result_o.weight_plus == '0);
  assign split_full = (result_o.weight_minus == WEIGHT_FULL - result_o.weight_plus);
  assign inner_word = result_strobe_o && !result_o.last;

  // the end word of a line carries no neighbor coverage
  `ALS_ASSERT_NOW(last_no_weight, result_strobe_o && result_o.last, no_weight)

  // a step word splits full coverage between its two neighbors
  `ALS_ASSERT_NOW(weights_sum_full, result_strobe_o, no_weight || split_full)

  // only the end word can follow another word of the same line with no gap
  `ALS_ASSERT_NEXT(no_gapless_inner, inner_word, !result_strobe_o || result_o.last)

  // the queue leaves full only when the walker pops, which puts out a start word
  `ALS_ASSERT_NEXT(busy_clears_by_pop, busy_o && !start_i, busy_o || result_strobe_o)

endmodule

bind antialiased_line_stepper als_checker u_als_checker (.*);

// ----- tb/sv/antialiased_line_stepper_tb.sv -----
`timescale 1ns / 1ps

module antialiased_line_stepper_tb;
  import als_pkg::*;

  localparam int unsigned SIDE      = SIDE_DEFAULT;
  localparam int unsigned LIMIT     = 2_000_000;
  localparam int unsigned RAND_LINES = 450;

  // expected pixel words of every accepted line, oldest first
  class line_scoreboard;
    result_t     queued_pixels[$];
    int unsigned mismatch_count;
    int unsigned lines_seen;
    int unsigned words_checked;
    int unsigned single_points;
    int unsigned clamped_lines;

    function int unsigned clamp_coord(logic [COORD_W-1:0] v);
      return (v > SIDE - 1) ? SIDE - 1 : int'(v);
    endfunction

    function result_t pixel_word(bit x_is_major, int unsigned maj, int unsigned mnr,
                                 int unsigned wm, int unsigned wp,
                                 logic [COLOR_W-1:0] col, bit fin);
      result_t w;
      w.pixel_x      = COORD_W'(x_is_major ? maj : mnr);
      w.pixel_y      = COORD_W'(x_is_major ? mnr : maj);
      w.x_major      = x_is_major;
      w.weight_minus = WEIGHT_W'(wm);
      w.weight_plus  = WEIGHT_W'(wp);
      w.pixel_color  = col;
      w.last         = fin;
      return w;
    endfunction

    // walk the line and queue the words it should produce
    function void note_line(line_t l);
      int unsigned xa, ya, xb, yb, ma, na, mb, nb, t;
      int unsigned dmaj, dmin, err, q, wm, wp, cur_maj, cur_min;
      bit x_is_major, minor_up;
      lines_seen++;
      if (l.x_start > SIDE - 1 || l.y_start > SIDE - 1 ||
          l.x_end > SIDE - 1 || l.y_end > SIDE - 1)
        clamped_lines++;
      xa = clamp_coord(l.x_start);
      ya = clamp_coord(l.y_start);
      xb = clamp_coord(l.x_end);
      yb = clamp_coord(l.y_end);
      x_is_major = ((xa > xb) ? xa - xb : xb - xa) >= ((ya > yb) ? ya - yb : yb - ya);
      if (x_is_major) begin
        ma = xa; na = ya; mb = xb; nb = yb;
      end else begin
        ma = ya; na = xa; mb = yb; nb = xb;
      end
      if (ma > mb) begin
        t = ma; ma = mb; mb = t;
        t = na; na = nb; nb = t;
      end
      dmaj     = mb - ma;
      dmin     = (na > nb) ? na - nb : nb - na;
      minor_up = nb > na;
      err      = dmaj >> 1;
      cur_maj  = ma;
      cur_min  = na;
      if (dmaj == 0) single_points++;
      queued_pixels.push_back(pixel_word(x_is_major, cur_maj, cur_min, 0, 0, l.color, 1'b0));
      while (cur_maj < mb) begin
        if (err < dmin) begin
          err = err + dmaj - dmin;
          cur_min = minor_up ? cur_min + 1 : cur_min - 1;
        end else begin
          err = err - dmin;
        end
        cur_maj++;
        q = (err * 256) / dmaj;
        if (q > 255) q = 255;
        if (minor_up) begin
          wp = 256 - q; wm = q;
        end else begin
          wp = q; wm = 256 - q;
        end
        queued_pixels.push_back(pixel_word(x_is_major, cur_maj, cur_min & 6'h3f, wm, wp,
                                           l.color, 1'b0));
      end
      queued_pixels.push_back(pixel_word(x_is_major, mb, nb, 0, 0, l.color, 1'b1));
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] seen);
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("%0t: word %0d %s expected %0h got %0h", $time, words_checked, field,
                 want, seen);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (queued_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 40)
          $display("%0t: unexpected word, expected none got %0h", $time, got);
        return;
      end
      want = queued_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x) report("pixel_x", want.pixel_x, got.pixel_x);
      if (got.pixel_y !== want.pixel_y) report("pixel_y", want.pixel_y, got.pixel_y);
      if (got.x_major !== want.x_major) report("x_major", want.x_major, got.x_major);
      if (got.weight_minus !== want.weight_minus)
        report("weight_minus", want.weight_minus, got.weight_minus);
      if (got.weight_plus !== want.weight_plus)
        report("weight_plus", want.weight_plus, got.weight_plus);
      if (got.pixel_color !== want.pixel_color)
        report("pixel_color", want.pixel_color, got.pixel_color);
      if (got.last !== want.last) report("last", want.last, got.last);
      words_checked++;
    endfunction

    function int unsigned pending();
      return queued_pixels.size();
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start_i;
  line_t   line_i;
  logic    busy_o;
  logic    result_strobe_o;
  result_t result_o;

  line_scoreboard sb = new();
  int unsigned    accepted_count = 0;
  int unsigned    cycle_count = 0;

  antialiased_line_stepper u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .line_i         (line_i),
    .busy_o         (busy_o),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      sb.note_line(line_i);
      accepted_count++;
    end
    if (rst_ni && result_strobe_o) sb.check_word(result_o);
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [COORD_W-1:0] fit(int v);
    return COORD_W'((v < 0) ? 0 : ((v > SIDE - 1) ? SIDE - 1 : v));
  endfunction

  function automatic line_t mk_line(int xs, int ys, int xe, int ye, logic [COLOR_W-1:0] col);
    line_t l;
    l.x_start = COORD_W'(xs);
    l.y_start = COORD_W'(ys);
    l.x_end   = COORD_W'(xe);
    l.y_end   = COORD_W'(ye);
    l.color   = col;
    return l;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(40, 150);
  endfunction

  // mostly short segments so the walk stays quick, some long and off-screen ones
  function automatic line_t random_line();
    int kind, xs, ys, dx, dy, len;
    logic [COLOR_W-1:0] col;
    kind = $urandom_range(0, 99);
    xs   = $urandom_range(0, SIDE - 1);
    ys   = $urandom_range(0, SIDE - 1);
    col  = COLOR_W'($urandom());
    if (kind < 60) begin
      dx = $urandom_range(0, 14);
      dy = $urandom_range(0, 14);
      dx -= 7;
      dy -= 7;
      return mk_line(xs, ys, fit(xs + dx), fit(ys + dy), col);
    end else if (kind < 75) begin
      len = $urandom_range(0, 10);
      if ($urandom_range(0, 1)) len = -len;
      case ($urandom_range(0, 3))
        0: return mk_line(xs, ys, fit(xs + len), ys, col);
        1: return mk_line(xs, ys, xs, fit(ys + len), col);
        2: return mk_line(xs, ys, fit(xs + len), fit(ys + len), col);
        default: return mk_line(xs, ys, fit(xs + len), fit(ys - len), col);
      endcase
    end else if (kind < 92) begin
      return mk_line($urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 63), $urandom_range(0, 63), col);
    end
    xs = $urandom_range(0, 63);
    ys = $urandom_range(0, 63);
    return mk_line(xs, ys, xs, ys, col);
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken, or at the end of the gap after it
  task automatic send_line(line_t l, int gap);
    int unsigned target;
    logic [63:0] noise;
    target = accepted_count + 1;
    start_i <= 1'b1;
    line_i  <= l;
    do @(negedge clk_i); while (accepted_count < target);
    if (gap > 0) begin
      noise = {$urandom(), $urandom()};
      start_i <= 1'b0;
      line_i  <= noise[$bits(line_t)-1:0];
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // drops start_i and waits on falling edges until no expected word is outstanding
  task automatic drain_lines();
    start_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    int  i;
    bit  burst;
    int  gap;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    line_i  = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // endpoints, axes, both walk directions, saturation and one-step lines
    send_line(mk_line(0, 0, 0, 0, 24'h000000), pick_gap());
    send_line(mk_line(55, 55, 55, 55, 24'hffffff), pick_gap());
    send_line(mk_line(63, 63, 63, 63, 24'hbf0000), pick_gap());
    send_line(mk_line(0, 0, 55, 0, 24'haaaaaa), pick_gap());
    send_line(mk_line(55, 0, 0, 0, 24'h555555), pick_gap());
    send_line(mk_line(0, 0, 0, 55, 24'hffffff), pick_gap());
    send_line(mk_line(0, 55, 0, 0, 24'h000000), pick_gap());
    send_line(mk_line(0, 0, 55, 55, 24'h123456), pick_gap());
    send_line(mk_line(55, 0, 0, 55, 24'hfedcba), pick_gap());
    send_line(mk_line(10, 20, 30, 25, 24'hbf0000), pick_gap());
    send_line(mk_line(10, 25, 30, 20, 24'h00ff00), pick_gap());
    send_line(mk_line(20, 10, 25, 30, 24'h0000ff), pick_gap());
    send_line(mk_line(25, 10, 20, 30, 24'hff0000), pick_gap());
    send_line(mk_line(63, 0, 0, 63, 24'h808080), pick_gap());
    send_line(mk_line(0, 63, 63, 0, 24'h7f7f7f), pick_gap());
    send_line(mk_line(40, 40, 41, 41, 24'hffffff), pick_gap());
    send_line(mk_line(40, 40, 41, 40, 24'h000001), pick_gap());
    send_line(mk_line(5, 5, 5, 6, 24'h800000), pick_gap());
    send_line(mk_line(0, 1, 55, 0, 24'h0f0f0f), 0);
    send_line(mk_line(56, 57, 58, 59, 24'hf0f0f0), 0);
    send_line(mk_line(1, 54, 54, 1, 24'hbf0000), 0);
    send_line(mk_line(0, 0, 55, 1, 24'h3c3c3c), 0);
    send_line(mk_line(54, 0, 55, 55, 24'hc3c3c3), pick_gap());
    drain_lines();

    burst = 1'b0;
    for (i = 0; i < RAND_LINES; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      if (i == RAND_LINES / 2) drain_lines();
      gap = burst ? 0 : pick_gap();
      send_line(random_line(), gap);
    end
    drain_lines();
    repeat (64) @(negedge clk_i);

    $display("%0d lines walked (%0d single-point, %0d with off-screen coordinates)",
             sb.lines_seen, sb.single_points, sb.clamped_lines);
    $display("%0d pixel words checked, %0d still outstanding", sb.words_checked,
             sb.pending());
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
